[sv/zsp_pkg.sv]
`default_nettype none
package zsp_pkg;

   localparam int SAMPLE_W = 16;
   localparam int POS_W    = 7;
   localparam int POS_MAX  = 127;
   localparam int SO_W     = 6;
   localparam int THR_W    = 8;
   localparam int INFL_W   = 9;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_START_OFFSET = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INFLUENCE    = 2'd2;

   localparam logic [SO_W-1:0]   SO_RESET   = 6'd10;
   localparam logic [THR_W-1:0]  THR_RESET  = 8'd16;
   localparam logic [INFL_W-1:0] INFL_RESET = 9'd128;
   localparam logic [INFL_W-1:0] INFL_ONE   = 9'd256;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_STORE,
      ST_SUM,
      ST_WY,
      ST_SS,
      ST_QL,
      ST_QH,
      ST_DD,
      ST_TT,
      ST_VL,
      ST_VH,
      ST_CMP,
      ST_BL,
      ST_BW,
      ST_DONE
   } state_type;

endpackage
`default_nettype wire

[sv/smoothed_zscore_peak_detector_unit.sv]
// Smoothed z-score peak detector for signed Q8.8 profile samples.
// req channel: one sample per transaction in req_tdata, req_tlast closes a read.
// rsp channel: one transaction per sample, boundary flag in rsp_tdata[0] and a
// copy of the last flag in rsp_tlast.
// csr channel: register writes (0 start_offset, 1 threshold, 2 influence), always
// ready; write only while the block is idle.
// From accept to rsp_tvalid: an ignored sample goes straight to DONE, a sample
// in warm-up is stored in the ring first, a tested sample runs the ring read
// loop, the multiply steps and the compare, and a flagged one is then blended
// and written back. The block takes one sample at a time and is ready again in
// the cycle after the result is loaded. A tested sample's time goes to the ring
// read loop, one entry a cycle into one shared multiplier, and to the eight
// multiply steps and the compare of the test.
// A finished result sits in an output register; the block accepts the next
// sample while it waits and only holds its next result until rsp_tready.
// Reset is synchronous and active high: registers return to their defaults,
// the read state restarts, the ring contents are undefined until written.
`default_nettype none
module smoothed_zscore_peak_detector_unit #(
   parameter int WINDOW = 10
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // [15:0] sample
   input  wire logic        req_tlast,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [7:0]  rsp_tdata,   // [0] boundary, [7:1] zero
   output logic             rsp_tlast,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [8:0]  csr_data
);

   localparam int DEPTH = WINDOW + 1;
   localparam int AW    = $clog2(DEPTH);
   localparam int LW    = $clog2(WINDOW);
   localparam int SW    = 16 + LW;
   localparam int DW    = SW + 1;
   localparam int MW    = DW;
   localparam int CH    = SW;
   localparam int QW    = 31 + LW;
   localparam int VW    = 2 * CH + 2;
   localparam int PW    = 2 * MW;
   localparam int RW    = 2 * CH + 17;
   localparam int CW    = $clog2(WINDOW + 2);
   localparam int BW    = 27;
   localparam int SMP_W = zsp_pkg::SAMPLE_W;
   localparam int POS_W = zsp_pkg::POS_W;

   localparam logic signed [MW-1:0] WIN_M     = MW'(WINDOW);
   localparam logic [CW-1:0]        LAST_RD   = CW'(WINDOW);
   localparam logic [CW-1:0]        END_CNT   = CW'(WINDOW + 1);
   localparam logic [AW-1:0]        LAST_ADDR = AW'(DEPTH - 1);

   zsp_pkg::state_type state_ff, state_in;

   logic [zsp_pkg::SO_W-1:0]   so_ff, so_in;
   logic [zsp_pkg::THR_W-1:0]  thr_ff, thr_in;
   logic [zsp_pkg::INFL_W-1:0] infl_ff, infl_in;

   logic signed [SMP_W-1:0] y_ff, y_in;
   logic                    last_ff, last_in;
   logic                    rise_ff, rise_in;
   logic [POS_W-1:0]        pos_ff, pos_in;
   logic signed [SMP_W-1:0] prev_ff, prev_in;
   logic [AW-1:0]           rp_ff, rp_in;
   logic [AW-1:0]           rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]           cnt_ff, cnt_in;
   logic                    rv_ff, rv_in;
   logic                    rn_ff, rn_in;
   logic                    mv_ff, mv_in;
   logic signed [SW-1:0]    s_ff, s_in;
   logic [QW-1:0]           q_ff, q_in;
   logic signed [SMP_W-1:0] pf_ff, pf_in;
   logic signed [DW-1:0]    d_ff, d_in;
   logic signed [VW-1:0]    var_ff, var_in;
   logic [PW-1:0]           dd_ff, dd_in;
   logic [15:0]             t2_ff, t2_in;
   logic [RW-1:0]           rhs_ff, rhs_in;
   logic                    bnd_ff, bnd_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_bnd_ff, rsp_bnd_in;
   logic                    rsp_last_ff, rsp_last_in;

   logic                    accept;
   logic                    done_fire;
   logic                    skip;
   logic                    store;
   logic [POS_W:0]          pos_ext;
   logic [POS_W:0]          so_ext;
   logic [POS_W:0]          win_hi;
   logic                    excess;
   logic                    d_pos;
   logic [RW-1:0]           lhs_w;
   logic [RW-1:0]           rhs_w;
   logic [zsp_pkg::INFL_W-1:0] w_sat;
   logic signed [16:0]      diff;
   logic signed [BW-1:0]    bl_v;
   logic signed [MW-1:0]    mul_a;
   logic signed [MW-1:0]    mul_b;
   logic signed [PW-1:0]    prod;
   logic                    wr_en;
   logic [SMP_W-1:0]        wr_data;
   logic [SMP_W-1:0]        rd_data;

   zsp_ring #(
      .DEPTH (DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (rp_ff),
      .wr_data (wr_data),
      .rd_addr (rd_ptr_ff),
      .rd_data (rd_data)
   );

   zsp_mul #(
      .WIDTH (MW)
   ) u_mul (
      .clock (clock),
      .a     (mul_a),
      .b     (mul_b),
      .prod  (prod)
   );

   // sample classification against the start offset
   always_comb begin
      pos_ext = {1'b0, pos_ff};
      so_ext  = (POS_W + 1)'(so_ff);
      win_hi  = so_ext + (POS_W + 1)'(WINDOW);
      skip    = pos_ext < so_ext;
      store   = !skip && (pos_ext <= win_hi);
   end

   // exact z-score test and blend
   always_comb begin
      d_pos  = !d_ff[DW-1] && (d_ff != '0);
      lhs_w  = RW'(dd_ff) << 8;
      rhs_w  = rhs_ff + (RW'($unsigned(prod)) << CH);
      excess = d_pos && (lhs_w > rhs_w);
      w_sat  = (infl_ff > zsp_pkg::INFL_ONE) ? zsp_pkg::INFL_ONE : infl_ff;
      diff   = 17'(y_ff) - 17'(pf_ff);
      bl_v   = $signed(prod[BW-1:0]) + (BW'(pf_ff) <<< 8) + BW'(128);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         zsp_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               if (skip) begin
                  state_in = zsp_pkg::ST_DONE;
               end else if (store) begin
                  state_in = zsp_pkg::ST_STORE;
               end else begin
                  state_in = zsp_pkg::ST_SUM;
               end
            end
         end
         zsp_pkg::ST_STORE: state_in = zsp_pkg::ST_DONE;
         zsp_pkg::ST_SUM: begin
            if (cnt_ff == END_CNT) begin
               state_in = zsp_pkg::ST_WY;
            end
         end
         zsp_pkg::ST_WY:  state_in = zsp_pkg::ST_SS;
         zsp_pkg::ST_SS:  state_in = zsp_pkg::ST_QL;
         zsp_pkg::ST_QL:  state_in = zsp_pkg::ST_QH;
         zsp_pkg::ST_QH:  state_in = zsp_pkg::ST_DD;
         zsp_pkg::ST_DD:  state_in = zsp_pkg::ST_TT;
         zsp_pkg::ST_TT:  state_in = zsp_pkg::ST_VL;
         zsp_pkg::ST_VL:  state_in = zsp_pkg::ST_VH;
         zsp_pkg::ST_VH:  state_in = zsp_pkg::ST_CMP;
         zsp_pkg::ST_CMP: begin
            if (excess && rise_ff) begin
               state_in = zsp_pkg::ST_BL;
            end else begin
               state_in = zsp_pkg::ST_DONE;
            end
         end
         zsp_pkg::ST_BL:  state_in = zsp_pkg::ST_BW;
         zsp_pkg::ST_BW:  state_in = zsp_pkg::ST_DONE;
         zsp_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               state_in = zsp_pkg::ST_IDLE;
            end
         end
         default: state_in = zsp_pkg::ST_IDLE;
      endcase
   end

   // state outputs: handshakes, ring write, multiplier operands
   always_comb begin
      req_tready = 1'b0;
      done_fire  = 1'b0;
      wr_en      = 1'b0;
      wr_data    = y_ff;
      mul_a      = '0;
      mul_b      = '0;
      if (rv_ff && !rn_ff) begin
         mul_a = MW'($signed(rd_data));
         mul_b = MW'($signed(rd_data));
      end
      unique case (state_ff)
         zsp_pkg::ST_IDLE:  req_tready = 1'b1;
         zsp_pkg::ST_STORE: wr_en = 1'b1;
         zsp_pkg::ST_SUM: begin
         end
         zsp_pkg::ST_WY: begin
            mul_a = WIN_M;
            mul_b = MW'(y_ff);
         end
         zsp_pkg::ST_SS: begin
            mul_a = MW'(s_ff);
            mul_b = MW'(s_ff);
         end
         zsp_pkg::ST_QL: begin
            mul_a = WIN_M;
            mul_b = MW'(q_ff[CH-1:0]);
         end
         zsp_pkg::ST_QH: begin
            mul_a = WIN_M;
            mul_b = MW'(q_ff[QW-1:CH]);
         end
         zsp_pkg::ST_DD: begin
            mul_a = d_ff;
            mul_b = d_ff;
         end
         zsp_pkg::ST_TT: begin
            mul_a = MW'(thr_ff);
            mul_b = MW'(thr_ff);
         end
         zsp_pkg::ST_VL: begin
            mul_a = MW'(prod[15:0]);
            mul_b = MW'(var_ff[CH-1:0]);
         end
         zsp_pkg::ST_VH: begin
            mul_a = MW'(t2_ff);
            mul_b = MW'(var_ff[2*CH-1:CH]);
         end
         zsp_pkg::ST_CMP:   wr_en = !(excess && rise_ff);
         zsp_pkg::ST_BL: begin
            mul_a = MW'(w_sat);
            mul_b = MW'(diff);
         end
         zsp_pkg::ST_BW: begin
            wr_en   = 1'b1;
            wr_data = bl_v[23:8];
         end
         zsp_pkg::ST_DONE:  done_fire = !rsp_valid_ff || rsp_tready;
         default: begin
         end
      endcase
      accept = req_tready && req_tvalid;
   end

   // datapath next values
   always_comb begin
      y_in      = y_ff;
      last_in   = last_ff;
      rise_in   = rise_ff;
      pos_in    = pos_ff;
      prev_in   = prev_ff;
      rp_in     = rp_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      s_in      = s_ff;
      q_in      = q_ff;
      pf_in     = pf_ff;
      d_in      = d_ff;
      var_in    = var_ff;
      dd_in     = dd_ff;
      t2_in     = t2_ff;
      rhs_in    = rhs_ff;
      bnd_in    = bnd_ff;
      rv_in     = (state_ff == zsp_pkg::ST_SUM) && (cnt_ff <= LAST_RD);
      rn_in     = (state_ff == zsp_pkg::ST_SUM) && (cnt_ff == LAST_RD);
      mv_in     = rv_ff && !rn_ff;

      rsp_valid_in = rsp_valid_ff;
      rsp_bnd_in   = rsp_bnd_ff;
      rsp_last_in  = rsp_last_ff;

      if (accept) begin
         y_in      = $signed(req_tdata);
         last_in   = req_tlast;
         rise_in   = prev_ff < $signed(req_tdata);
         s_in      = '0;
         q_in      = '0;
         rd_ptr_in = rp_ff;
         cnt_in    = '0;
         bnd_in    = 1'b0;
      end

      if (state_ff == zsp_pkg::ST_SUM) begin
         cnt_in    = cnt_ff + CW'(1);
         rd_ptr_in = (rd_ptr_ff == LAST_ADDR) ? '0 : rd_ptr_ff + AW'(1);
      end

      if (rv_ff && !rn_ff) begin
         s_in = s_ff + SW'($signed(rd_data));
      end
      if (rv_ff && rn_ff) begin
         pf_in = $signed(rd_data);
      end
      if (mv_ff) begin
         q_in = q_ff + QW'($unsigned(prod));
      end

      case (state_ff)
         zsp_pkg::ST_SS:  d_in   = DW'(prod) - DW'(s_ff);
         zsp_pkg::ST_QL:  var_in = -VW'(prod);
         zsp_pkg::ST_QH:  var_in = var_ff + VW'(prod);
         zsp_pkg::ST_DD:  var_in = var_ff + (VW'(prod) <<< CH);
         zsp_pkg::ST_TT:  dd_in  = $unsigned(prod);
         zsp_pkg::ST_VL:  t2_in  = prod[15:0];
         zsp_pkg::ST_VH:  rhs_in = RW'($unsigned(prod));
         zsp_pkg::ST_CMP: bnd_in = excess && rise_ff;
         default: begin
         end
      endcase

      if (wr_en) begin
         rp_in = (rp_ff == LAST_ADDR) ? '0 : rp_ff + AW'(1);
      end

      if (done_fire) begin
         rsp_valid_in = 1'b1;
         rsp_bnd_in   = bnd_ff;
         rsp_last_in  = last_ff;
         if (last_ff) begin
            rp_in   = '0;
            prev_in = '0;
            pos_in  = '0;
         end else begin
            prev_in = y_ff;
            if (pos_ff < POS_W'(zsp_pkg::POS_MAX)) begin
               pos_in = pos_ff + POS_W'(1);
            end
         end
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // register writes
   always_comb begin
      so_in   = so_ff;
      thr_in  = thr_ff;
      infl_in = infl_ff;
      if (csr_valid) begin
         unique case (csr_index)
            zsp_pkg::CSR_START_OFFSET: so_in   = csr_data[zsp_pkg::SO_W-1:0];
            zsp_pkg::CSR_THRESHOLD:    thr_in  = csr_data[zsp_pkg::THR_W-1:0];
            zsp_pkg::CSR_INFLUENCE:    infl_in = csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= zsp_pkg::ST_IDLE;
         so_ff        <= zsp_pkg::SO_RESET;
         thr_ff       <= zsp_pkg::THR_RESET;
         infl_ff      <= zsp_pkg::INFL_RESET;
         pos_ff       <= '0;
         prev_ff      <= '0;
         rp_ff        <= '0;
         rv_ff        <= 1'b0;
         rn_ff        <= 1'b0;
         mv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         so_ff        <= so_in;
         thr_ff       <= thr_in;
         infl_ff      <= infl_in;
         pos_ff       <= pos_in;
         prev_ff      <= prev_in;
         rp_ff        <= rp_in;
         rv_ff        <= rv_in;
         rn_ff        <= rn_in;
         mv_ff        <= mv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      y_ff        <= y_in;
      last_ff     <= last_in;
      rise_ff     <= rise_in;
      rd_ptr_ff   <= rd_ptr_in;
      cnt_ff      <= cnt_in;
      s_ff        <= s_in;
      q_ff        <= q_in;
      pf_ff       <= pf_in;
      d_ff        <= d_in;
      var_ff      <= var_in;
      dd_ff       <= dd_in;
      t2_ff       <= t2_in;
      rhs_ff      <= rhs_in;
      bnd_ff      <= bnd_in;
      rsp_bnd_ff  <= rsp_bnd_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_bnd_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule
`default_nettype wire

[sv/zsp_ring.sv]
`default_nettype none
module zsp_ring #(
   parameter int DEPTH = 11
) (
   input  wire logic                         clock,
   input  wire logic                         wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]     wr_addr,
   input  wire logic [zsp_pkg::SAMPLE_W-1:0] wr_data,
   input  wire logic [$clog2(DEPTH)-1:0]     rd_addr,
   output logic      [zsp_pkg::SAMPLE_W-1:0] rd_data
);

   logic [zsp_pkg::SAMPLE_W-1:0] mem [DEPTH];
   logic [zsp_pkg::SAMPLE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

[sv/zsp_mul.sv]
`default_nettype none
module zsp_mul #(
   parameter int WIDTH = 21
) (
   input  wire logic                      clock,
   input  wire logic signed [WIDTH-1:0]   a,
   input  wire logic signed [WIDTH-1:0]   b,
   output logic      signed [2*WIDTH-1:0] prod
);

   logic signed [2*WIDTH-1:0] prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= a * b;
   end

   assign prod = prod_ff;

endmodule
`default_nettype wire
